// File: src/ogi_pkg.sv
package ogi_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_REACH  = 15;

	localparam int COORD_W = 8;
	localparam int VALUE_W = 8;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 2;
	// signed neighbor coordinate: 8-bit cell plus offset up to +/-15
	localparam int NB_W = 10;

	localparam logic signed [VALUE_W-1:0] OBSTACLE_LEVEL = 8'sd100;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REACH_CELLS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = 2'd3;

	localparam logic [8:0] RST_GRID_WIDTH  = 9'd256;
	localparam logic [8:0] RST_GRID_HEIGHT = 9'd256;
	localparam logic [3:0] RST_REACH_CELLS = 4'd0;
	localparam logic [7:0] RST_RADIUS_SQ   = 8'd0;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CENTER = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	typedef struct packed {
		logic write;      // store the incoming load word
		logic capture;    // latch read coordinates, restart the scan
		logic rd_center;  // fetch the addressed cell
		logic rd_scan;    // fetch the current neighbor and advance
		logic load_out;   // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic in_inside;  // incoming word addresses a cell in the grid
		logic scan_last;  // current offset is the last of the square
	} status_t;

endpackage

// File: src/ogi_ram.sv
module ogi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: src/ogi_ctrl.sv
module ogi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	output logic             out_valid,
	input  logic             out_stall,
	input  ogi_pkg::status_t status,
	output ogi_pkg::cmd_t    cmd
);

	ogi_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic accept;

	assign in_stall  = (state_q != ogi_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == ogi_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ogi_pkg::ST_IDLE: begin
				if (accept && kind == ogi_pkg::KIND_LOAD) begin
					cmd.write = 1'b1;
				end else if (accept) begin
					cmd.capture = 1'b1;
					state_d = status.in_inside ? ogi_pkg::ST_CENTER : ogi_pkg::ST_FINISH;
				end
			end
			ogi_pkg::ST_CENTER: begin
				cmd.rd_center = 1'b1;
				state_d = ogi_pkg::ST_SCAN;
			end
			ogi_pkg::ST_SCAN: begin
				cmd.rd_scan = 1'b1;
				if (status.scan_last) begin
					state_d = ogi_pkg::ST_DRAIN;
				end
			end
			ogi_pkg::ST_DRAIN: begin
				// last neighbor word lands this cycle
				state_d = ogi_pkg::ST_FINISH;
			end
			ogi_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = ogi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ogi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ogi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/ogi_datapath.sv
module ogi_datapath #(
	parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ogi_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_REACH  = ogi_pkg::DEF_MAX_REACH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [ogi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ogi_pkg::CFG_W-1:0]            cfg_data,
	input  logic [ogi_pkg::COORD_W-1:0]          cell_x,
	input  logic [ogi_pkg::COORD_W-1:0]          cell_y,
	input  logic signed [ogi_pkg::VALUE_W-1:0]   cell_value,
	input  ogi_pkg::cmd_t                        cmd,
	output ogi_pkg::status_t                     status,
	output logic signed [ogi_pkg::VALUE_W-1:0]   inflated_value,
	output logic                                 in_range
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_REACH > 0) ? $clog2(MAX_REACH + 1) : 1;
	localparam int OW    = RW + 1;
	localparam int NW    = ogi_pkg::NB_W;
	localparam int VW    = ogi_pkg::VALUE_W;

	logic [8:0] grid_width_q, grid_height_q;
	logic [3:0] reach_cells_q;
	logic [7:0] radius_sq_q;

	logic [8:0]  w_eff, h_eff;
	logic [RW-1:0] reach;
	logic signed [OW-1:0] reach_pos, reach_neg;

	logic [ogi_pkg::COORD_W-1:0] x_q, y_q;
	logic                        inside_q;
	logic signed [OW-1:0]        dx_q, dy_q;
	logic                        ctr_s1, chk_s1;
	logic signed [VW-1:0]        orig_q;
	logic                        hit_q;

	logic signed [NW-1:0] nx, ny;
	logic [RW-1:0]        adx, ady;
	logic [2*RW:0]        dist_sq;
	logic                 nb_ok;

	logic [AW-1:0]  wr_addr, ctr_addr, nb_addr, ram_addr;
	logic [VW-1:0]  ram_rdata;
	logic           ram_we;
	logic           obstacle;

	// effective sizes clamp to what the memory holds
	assign w_eff = (32'(grid_width_q) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : grid_width_q;
	assign h_eff = (32'(grid_height_q) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : grid_height_q;
	assign reach = (32'(reach_cells_q) > 32'(MAX_REACH)) ? RW'(MAX_REACH) : RW'(reach_cells_q);
	assign reach_pos = $signed({1'b0, reach});
	assign reach_neg = -reach_pos;

	assign status.in_inside = ({1'b0, cell_x} < w_eff) && ({1'b0, cell_y} < h_eff);
	assign status.scan_last = (dx_q == reach_pos) && (dy_q == reach_pos);

	assign nx = $signed({{(NW-ogi_pkg::COORD_W){1'b0}}, x_q}) + {{(NW-OW){dx_q[OW-1]}}, dx_q};
	assign ny = $signed({{(NW-ogi_pkg::COORD_W){1'b0}}, y_q}) + {{(NW-OW){dy_q[OW-1]}}, dy_q};

	assign adx = dx_q[OW-1] ? RW'(-dx_q) : RW'(dx_q);
	assign ady = dy_q[OW-1] ? RW'(-dy_q) : RW'(dy_q);
	assign dist_sq = (2*RW+1)'(adx * adx) + (2*RW+1)'(ady * ady);

	assign nb_ok = !nx[NW-1] && !ny[NW-1] && (nx[8:0] < w_eff) && (ny[8:0] < h_eff)
		&& (32'(dist_sq) <= 32'(radius_sq_q));

	assign wr_addr  = AW'(32'(cell_y) * MAX_WIDTH + 32'(cell_x));
	assign ctr_addr = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
	assign nb_addr  = AW'(32'(ny[7:0]) * MAX_WIDTH + 32'(nx[7:0]));

	always_comb begin
		if (cmd.write) begin
			ram_addr = wr_addr;
		end else if (cmd.rd_center) begin
			ram_addr = ctr_addr;
		end else begin
			ram_addr = nb_addr;
		end
	end

	assign ram_we = cmd.write && status.in_inside;

	ogi_ram #(
		.WIDTH(VW),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(cell_value),
		.rdata(ram_rdata)
	);

	assign obstacle = ($signed(ram_rdata) >= ogi_pkg::OBSTACLE_LEVEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= ogi_pkg::RST_GRID_WIDTH;
			grid_height_q <= ogi_pkg::RST_GRID_HEIGHT;
			reach_cells_q <= ogi_pkg::RST_REACH_CELLS;
			radius_sq_q   <= ogi_pkg::RST_RADIUS_SQ;
			dx_q          <= '0;
			dy_q          <= '0;
			ctr_s1        <= 1'b0;
			chk_s1        <= 1'b0;
			hit_q         <= 1'b0;
			inside_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					ogi_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					ogi_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					ogi_pkg::REG_REACH_CELLS: reach_cells_q <= cfg_data[3:0];
					ogi_pkg::REG_RADIUS_SQ:   radius_sq_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			ctr_s1 <= cmd.rd_center;
			chk_s1 <= cmd.rd_scan && nb_ok;
			if (cmd.capture) begin
				dx_q     <= reach_neg;
				dy_q     <= reach_neg;
				hit_q    <= 1'b0;
				inside_q <= status.in_inside;
			end else begin
				if (cmd.rd_scan) begin
					// raster over the square, row by row
					if (dx_q == reach_pos) begin
						dx_q <= reach_neg;
						dy_q <= dy_q + OW'(1);
					end else begin
						dx_q <= dx_q + OW'(1);
					end
				end
				if (chk_s1 && obstacle) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= cell_x;
			y_q <= cell_y;
		end
		if (ctr_s1) begin
			orig_q <= $signed(ram_rdata);
		end
		if (cmd.load_out) begin
			in_range <= inside_q;
			if (!inside_q) begin
				inflated_value <= '0;
			end else if (hit_q && orig_q < ogi_pkg::OBSTACLE_LEVEL) begin
				inflated_value <= ogi_pkg::OBSTACLE_LEVEL;
			end else begin
				inflated_value <= orig_q;
			end
		end
	end

endmodule

// File: src/occupancy_grid_obstacle_inflation.sv
// Obstacle inflation over a stored occupancy grid. A load word (kind 0) writes one signed
// 8-bit cell at (cell_x, cell_y); loads outside the configured grid are dropped. A read word
// (kind 1) returns max(original, 100) when any cell of value 100 or more lies within the disk
// dx*dx+dy*dy <= radius_sq_limit, |dx|,|dy| <= reach, else the original. For a read inside
// the grid the block fetches the addressed cell, then every neighbor of the square one per
// cycle through the single port of the grid memory, waits for the last read and then loads
// the result; no new word is taken until the result is loaded. A read outside the grid
// returns 0 with in_range low and skips the fetches. A result held by out_stall delays the
// next result and the next word. The grid memory is not cleared at reset; every cell a
// read touches must have been loaded first. Write configuration only while the block is idle.
module occupancy_grid_obstacle_inflation #(
	parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ogi_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_REACH  = ogi_pkg::DEF_MAX_REACH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ogi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ogi_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [ogi_pkg::COORD_W-1:0]         cell_x,
	input  logic [ogi_pkg::COORD_W-1:0]         cell_y,
	input  logic signed [ogi_pkg::VALUE_W-1:0]  cell_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ogi_pkg::VALUE_W-1:0]  inflated_value,
	output logic                                in_range
);

	ogi_pkg::cmd_t    cmd;
	ogi_pkg::status_t status;

	ogi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ogi_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_REACH (MAX_REACH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.cell_value    (cell_value),
		.cmd           (cmd),
		.status        (status),
		.inflated_value(inflated_value),
		.in_range      (in_range)
	);

	// one memory port: a load never shares a cycle with a scan fetch
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !(cmd.rd_center || cmd.rd_scan))
		else $error("grid write collides with read");

	// a waiting result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result register overrun");

	// the addressed cell fetch is always followed by the neighbor scan
	a_center_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_center |=> (cmd.rd_scan && in_stall))
		else $error("scan did not follow center fetch");

	// a new word is taken only while no read is under way
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_scan || cmd.rd_center) |-> in_stall)
		else $error("input accepted during scan");

endmodule

// File: tb/occupancy_grid_checker.sv
`timescale 1ns / 100ps

module occupancy_grid_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ogi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ogi_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                kind,
	input  logic [ogi_pkg::COORD_W-1:0]         cell_x,
	input  logic [ogi_pkg::COORD_W-1:0]         cell_y,
	input  logic signed [ogi_pkg::VALUE_W-1:0]  cell_value,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [ogi_pkg::VALUE_W-1:0]  inflated_value,
	input  logic                                in_range,
	output int                                  fail_count,
	output int                                  pending
);

	typedef struct packed {
		logic signed [ogi_pkg::VALUE_W-1:0] value;
		logic                               in_range;
	} cell_result_t;

	localparam int GRID_CELLS = ogi_pkg::DEF_MAX_WIDTH * ogi_pkg::DEF_MAX_HEIGHT;

	logic signed [ogi_pkg::VALUE_W-1:0] grid_mem [0:GRID_CELLS-1];
	logic [8:0] grid_w;
	logic [8:0] grid_h;
	logic [3:0] reach;
	logic [7:0] radius_lim;
	cell_result_t read_results [$];
	int err_cnt = 0;
	int pending_cnt = 0;

	assign fail_count = err_cnt;
	assign pending = pending_cnt;

	function automatic int extent(input logic [8:0] v, input int cap);
		return (int'(v) > cap) ? cap : int'(v);
	endfunction

	// gather over the disk around (x,y); any obstacle lifts the cell to the obstacle level
	function automatic cell_result_t inflate_cell(input logic [7:0] x, input logic [7:0] y);
		int w;
		int h;
		int dx;
		int dy;
		int nx;
		int ny;
		bit near;
		logic signed [ogi_pkg::VALUE_W-1:0] orig;
		cell_result_t res;
		w = extent(grid_w, ogi_pkg::DEF_MAX_WIDTH);
		h = extent(grid_h, ogi_pkg::DEF_MAX_HEIGHT);
		res.value = '0;
		res.in_range = 1'b0;
		if (int'(x) < w && int'(y) < h) begin
			near = 1'b0;
			for (dy = -int'(reach); dy <= int'(reach); dy++) begin
				for (dx = -int'(reach); dx <= int'(reach); dx++) begin
					nx = int'(x) + dx;
					ny = int'(y) + dy;
					if (nx >= 0 && ny >= 0 && nx < w && ny < h &&
							dx * dx + dy * dy <= int'(radius_lim)) begin
						if (grid_mem[ny * ogi_pkg::DEF_MAX_WIDTH + nx] >=
								ogi_pkg::OBSTACLE_LEVEL)
							near = 1'b1;
					end
				end
			end
			orig = grid_mem[int'(y) * ogi_pkg::DEF_MAX_WIDTH + int'(x)];
			if (near && orig < ogi_pkg::OBSTACLE_LEVEL)
				orig = ogi_pkg::OBSTACLE_LEVEL;
			res.value = orig;
			res.in_range = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			grid_w = ogi_pkg::RST_GRID_WIDTH;
			grid_h = ogi_pkg::RST_GRID_HEIGHT;
			reach = ogi_pkg::RST_REACH_CELLS;
			radius_lim = ogi_pkg::RST_RADIUS_SQ;
			read_results.delete();
			pending_cnt = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					ogi_pkg::REG_GRID_WIDTH: grid_w = cfg_data;
					ogi_pkg::REG_GRID_HEIGHT: grid_h = cfg_data;
					ogi_pkg::REG_REACH_CELLS: reach = cfg_data[3:0];
					ogi_pkg::REG_RADIUS_SQ: radius_lim = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (read_results.size() == 0) begin
					$error("result word with no read outstanding: value %0d in_range %0b",
						inflated_value, in_range);
					err_cnt++;
				end else begin
					want = read_results.pop_front();
					if (inflated_value !== want.value) begin
						$error("inflated_value: expected %0d, actual %0d",
							$signed(want.value), inflated_value);
						err_cnt++;
					end
					if (in_range !== want.in_range) begin
						$error("in_range: expected %0b, actual %0b", want.in_range, in_range);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == ogi_pkg::KIND_READ) begin
					read_results.push_back(inflate_cell(cell_x, cell_y));
				end else if (int'(cell_x) < extent(grid_w, ogi_pkg::DEF_MAX_WIDTH) &&
						int'(cell_y) < extent(grid_h, ogi_pkg::DEF_MAX_HEIGHT)) begin
					grid_mem[int'(cell_y) * ogi_pkg::DEF_MAX_WIDTH + int'(cell_x)] = cell_value;
				end
			end
			pending_cnt = read_results.size();
		end
	end

endmodule

// File: tb/tb_occupancy_grid_obstacle_inflation.sv
`timescale 1ns / 100ps

module tb_occupancy_grid_obstacle_inflation;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int ITEM_TARGET = 620;
	localparam int GRID_CELLS = ogi_pkg::DEF_MAX_WIDTH * ogi_pkg::DEF_MAX_HEIGHT;

	typedef enum int {RX_FREE, RX_COIN, RX_TOGGLE, RX_HEAVY} rx_mode_t;
	typedef logic [ogi_pkg::COORD_W-1:0] coord_t;
	typedef logic signed [ogi_pkg::VALUE_W-1:0] value_t;
	typedef logic [ogi_pkg::CFG_W-1:0] cfg_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [ogi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	cfg_word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = ogi_pkg::KIND_LOAD;
	coord_t cell_x = '0;
	coord_t cell_y = '0;
	value_t cell_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	value_t inflated_value;
	logic in_range;

	int check_failures;
	int pending;

	// stimulus-side view of the grid: which cells hold a known value, and the setting in force
	bit written [0:GRID_CELLS-1];
	int cur_w = 256;
	int cur_h = 256;
	int cur_reach = 0;

	int burst_left = 1;
	int n_items = 0;
	int n_loads = 0;
	int n_reads = 0;
	int n_settings = 0;
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	occupancy_grid_obstacle_inflation u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.inflated_value(inflated_value), .in_range(in_range)
	);

	occupancy_grid_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.inflated_value(inflated_value), .in_range(in_range),
		.fail_count(check_failures), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver: random stall modes, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 200);
				end
				mode_left--;
				case (mode)
					RX_FREE: out_stall <= 1'b0;
					RX_COIN: out_stall <= 1'($urandom_range(0, 1));
					RX_TOGGLE: out_stall <= ~out_stall;
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic int grid_extent(input int v, input int cap);
		return (v > cap) ? cap : v;
	endfunction

	// every cell of the search square that lies in the grid must already hold a value
	function automatic bit safe_to_read(input int x, input int y);
		int aw;
		int ah;
		int dx;
		int dy;
		int nx;
		int ny;
		bit ok;
		aw = grid_extent(cur_w, ogi_pkg::DEF_MAX_WIDTH);
		ah = grid_extent(cur_h, ogi_pkg::DEF_MAX_HEIGHT);
		ok = 1'b1;
		if (x < aw && y < ah) begin
			for (dy = -cur_reach; dy <= cur_reach; dy++) begin
				for (dx = -cur_reach; dx <= cur_reach; dx++) begin
					nx = x + dx;
					ny = y + dy;
					if (nx >= 0 && ny >= 0 && nx < aw && ny < ah &&
							!written[ny * ogi_pkg::DEF_MAX_WIDTH + nx])
						ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	function automatic value_t pick_value();
		value_t v;
		case ($urandom_range(0, 9))
			0, 1: v = value_t'($urandom_range(100, 127));
			2: v = -8'sd1;
			3: v = value_t'($urandom);
			4: v = 8'sd99;
			default: v = value_t'($urandom_range(0, 99));
		endcase
		return v;
	endfunction

	task automatic send_word(input logic k, input int x, input int y, input value_t v);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		cell_x <= coord_t'(x);
		cell_y <= coord_t'(y);
		cell_value <= v;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic load_cell(input int x, input int y, input value_t v);
		if (x < grid_extent(cur_w, ogi_pkg::DEF_MAX_WIDTH) &&
				y < grid_extent(cur_h, ogi_pkg::DEF_MAX_HEIGHT)) begin
			written[y * ogi_pkg::DEF_MAX_WIDTH + x] = 1'b1;
			n_items++;
		end
		n_loads++;
		send_word(ogi_pkg::KIND_LOAD, x, y, v);
	endtask

	task automatic read_cell(input int x, input int y);
		n_items++;
		n_reads++;
		send_word(ogi_pkg::KIND_READ, x, y, value_t'($urandom));
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [ogi_pkg::CFG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= cfg_word_t'(data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// registers change only with the block drained; the wait also covers a trailing load
	task automatic set_grid(input int w, input int h, input int r, input int lim);
		drop_valid();
		wait (pending == 0);
		repeat (8) @(posedge clk);
		write_reg(ogi_pkg::REG_GRID_WIDTH, w);
		write_reg(ogi_pkg::REG_GRID_HEIGHT, h);
		write_reg(ogi_pkg::REG_REACH_CELLS, r);
		write_reg(ogi_pkg::REG_RADIUS_SQ, lim);
		cur_w = w;
		cur_h = h;
		cur_reach = r;
		n_settings++;
	endtask

	// mostly reads around the preloaded corner, some loads, a few anywhere in the plane
	task automatic random_phase(input int count);
		int i;
		int t;
		int x;
		int y;
		bit found;
		for (i = 0; i < count; i++) begin
			found = 1'b0;
			if ($urandom_range(0, 9) < 6) begin
				for (t = 0; t < 8 && !found; t++) begin
					if ($urandom_range(0, 9) == 0) begin
						x = $urandom_range(0, 255);
						y = $urandom_range(0, 255);
					end else begin
						x = $urandom_range(0, 17);
						y = $urandom_range(0, 17);
					end
					found = safe_to_read(x, y);
				end
			end
			if (found) begin
				read_cell(x, y);
			end else if ($urandom_range(0, 4) == 0) begin
				load_cell($urandom_range(0, 255), $urandom_range(0, 255), pick_value());
			end else begin
				load_cell($urandom_range(0, 15), $urandom_range(0, 15), pick_value());
			end
		end
	endtask

	initial begin
		int x;
		int y;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: full grid, self only
		load_cell(0, 0, 8'sd127);
		load_cell(255, 255, -8'sd128);
		load_cell(255, 0, 8'sd100);
		load_cell(0, 255, -8'sd1);
		read_cell(0, 0);
		read_cell(255, 255);
		read_cell(255, 0);
		read_cell(0, 255);

		// reads and loads past the edge
		set_grid(16, 16, 1, 1);
		load_cell(200, 3, 8'sd5);
		read_cell(255, 255);
		read_cell(16, 0);

		// zero width: nothing is in range, load dropped
		set_grid(0, 256, 0, 0);
		read_cell(0, 0);
		load_cell(0, 0, 8'sd3);

		// width past the maximum saturates
		set_grid(511, 256, 0, 0);
		read_cell(0, 0);
		read_cell(255, 0);

		set_grid(256, 0, 0, 0);
		read_cell(0, 0);

		// preload the corner that the random reads work around
		set_grid(256, 256, 0, 0);
		for (y = 0; y < 16; y++)
			for (x = 0; x < 16; x++)
				load_cell(x, y, pick_value());

		set_grid(16, 16, 15, 255);
		random_phase(30);
		set_grid(16, 16, 0, 0);
		hold_req = 1'b1;
		random_phase(40);
		set_grid(16, 16, 2, 4);
		random_phase(30);
		set_grid(12, 16, 3, 9);
		random_phase(30);
		set_grid(256, 256, 15, 255);
		random_phase(20);
		set_grid(1, 1, 15, 255);
		random_phase(20);
		set_grid(16, 5, 7, 30);
		random_phase(30);
		set_grid(511, 300, 1, 2);
		random_phase(30);
		set_grid(16, 16, 15, 0);
		random_phase(20);
		set_grid(16, 16, 4, 255);
		random_phase(30);
		while (n_items < ITEM_TARGET) begin
			set_grid($urandom_range(1, 17), $urandom_range(1, 17), $urandom_range(0, 15),
				$urandom_range(0, 255));
			random_phase(30);
		end

		drop_valid();
		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d loads and %0d reads over %0d grid settings,",
			n_loads, n_reads, n_settings);
		$display("with clipped edges, zero and saturated sizes and a long output hold-off.");
		if (check_failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
